/* src/shabh_pkg.sv */
`timescale 1ns / 1ps

package shabh_pkg;

   localparam int NumChain   = 8;
   localparam int NumSched   = 16;
   localparam int NumRounds  = 64;
   localparam int NumDigest  = 7;
   localparam int QueueDepth = 2;

   localparam logic [31:0] ShaIv [NumChain] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam logic [31:0] RoundK [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [31:0] message_word;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef struct packed {
      logic [NumSched-1:0][31:0] words;
      logic                      final_block;
   } blk_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

/* src/shabh_front.sv */
`timescale 1ns / 1ps

module shabh_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  shabh_pkg::req_type     req_data,
   input  shabh_pkg::q_status_type status,
   output logic                   push,
   output shabh_pkg::blk_type     push_blk
);
   import shabh_pkg::*;

   logic [3:0]  count_ff, count_in;
   logic [31:0] buf_ff [NumSched];
   logic        accept;

   assign accept = start & ~status.full;
   assign push   = accept & (req_data.final_word | (count_ff == 4'(NumSched - 1)));

   // stale words past the current position read as zero on a short final block
   always_comb begin
      for (int i = 0; i < NumSched; i++) begin
         if (4'(i) < count_ff) begin
            push_blk.words[i] = buf_ff[i];
         end else if (4'(i) == count_ff) begin
            push_blk.words[i] = req_data.message_word;
         end else begin
            push_blk.words[i] = '0;
         end
      end
      push_blk.final_block = req_data.final_word;
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = '0;
      end else if (accept) begin
         count_in = count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[count_ff] <= req_data.message_word;
      end
   end

endmodule

/* src/shabh_queue.sv */
`timescale 1ns / 1ps

module shabh_queue #(
   parameter int DEPTH = shabh_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  shabh_pkg::blk_type      push_blk,
   input  logic                    pop,
   output shabh_pkg::blk_type      head_blk,
   output shabh_pkg::q_status_type status
);
   import shabh_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   blk_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CntW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_blk     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_blk;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("block pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("block popped from empty queue");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue fill count lost a push");

endmodule

/* src/shabh_back.sv */
`timescale 1ns / 1ps

module shabh_back (
   input  logic                    clock,
   input  logic                    reset,
   input  shabh_pkg::q_status_type status,
   input  shabh_pkg::blk_type      head_blk,
   output logic                    pop,
   output logic                    rsp_valid,
   output shabh_pkg::rsp_type      rsp_data
);
   import shabh_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_EMIT  = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;
   logic [31:0] chain_ff [NumChain];
   logic [31:0] chain_in [NumChain];
   logic [31:0] work_ff [NumChain];
   logic [31:0] work_in [NumChain];
   logic [31:0] w_ff [NumSched];
   logic [31:0] w_in [NumSched];

   logic [31:0] t1, t2, ch, mj, w_next;

   // w_ff[0] is the schedule word of the current round
   always_comb begin
      ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      mj     = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t1     = work_ff[7] + big_sigma1(work_ff[4]) + ch + RoundK[round_ff] + w_ff[0];
      t2     = big_sigma0(work_ff[0]) + mj;
      w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
   end

   assign pop                  = (state_ff == ST_IDLE) & ~status.empty;
   assign rsp_valid            = (state_ff == ST_EMIT);
   assign rsp_data.digest_word = chain_ff[idx_ff];
   assign rsp_data.digest_last = (idx_ff == 3'(NumDigest - 1));

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      fin_in   = fin_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      w_in     = w_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               for (int i = 0; i < NumSched; i++) begin
                  w_in[i] = head_blk.words[i];
               end
               work_in  = chain_ff;
               fin_in   = head_blk.final_block;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < NumSched - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[NumSched - 1] = w_next;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < NumChain; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            idx_in   = '0;
            state_in = fin_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'(NumDigest - 1)) begin
               chain_in = ShaIv;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
         fin_ff   <= 1'b0;
         chain_ff <= ShaIv;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         fin_ff   <= fin_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      w_ff    <= w_in;
   end

   a_fold_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> ($past(state_ff) == ST_ROUND && $past(round_ff) == 6'd63))
      else $error("chain fold without a full set of rounds");
   a_pop_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_ROUND && round_ff == '0))
      else $error("popped block did not start compression");
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.digest_last) |=> !rsp_valid)
      else $error("strobe continued past last digest word");

endmodule

/* src/sha224_block_hash_top.sv */
`timescale 1ns / 1ps

// SHA-224 over an already padded message, fed one big-endian word per transaction
// (start high while busy is low), sixteen words per block; final_word marks the
// last word, and a short last block is zero-filled. Words go into a block buffer
// and whole blocks wait in a small block queue, so busy rises only when that queue
// is full. A single round unit runs one SHA-256 round per cycle: it loads a block
// from the queue, runs the 64 rounds and then folds the working words into the
// chaining words, and takes the next block only once that fold is done. After the
// last block the seven digest words H0..H6 are strobed on rsp_valid in consecutive
// cycles, digest_last on H6, and no new block is loaded during them; the receiver
// must take each one in its cycle, there is no back-pressure.
module sha224_block_hash_top #(
   parameter int QUEUE_DEPTH = shabh_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  shabh_pkg::req_type req_data,
   output logic               rsp_valid,
   output shabh_pkg::rsp_type rsp_data
);
   import shabh_pkg::*;

   q_status_type q_status;
   blk_type      push_blk, head_blk;
   logic         push, pop;

   assign busy = q_status.full;

   shabh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (q_status),
      .push     (push),
      .push_blk (push_blk)
   );

   shabh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .head_blk (head_blk),
      .status   (q_status)
   );

   shabh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (q_status),
      .head_blk  (head_blk),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
